// ===== sv/double_ended_queue_unit_defines.svh =====
// Assertion macros for the double-ended queue unit.
// No dependencies; taken in by `include where assertions are written.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Check that cons holds in the cycle after ante.
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define DEQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Constants, codes and types shared by the double-ended queue unit.
// No dependencies.
`default_nettype none
package deq_pkg;
   localparam int DEPTH        = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int ADDR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int SUM_WIDTH    = COUNT_WIDTH + 1;
   localparam int OP_WIDTH     = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int LENGTH_WIDTH = 5;

   typedef logic [ADDR_WIDTH-1:0]   addr_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [SUM_WIDTH-1:0]    sum_type;
   typedef logic [OP_WIDTH-1:0]     op_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;
   typedef logic [LENGTH_WIDTH-1:0] length_type;
   typedef logic [DATA_WIDTH-1:0]   data_type;

   localparam op_type OP_PUSH_REAR  = 3'd0;
   localparam op_type OP_POP_FRONT  = 3'd1;
   localparam op_type OP_PUSH_FRONT = 3'd2;
   localparam op_type OP_POP_REAR   = 3'd3;
   localparam op_type OP_CLEAR      = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
endpackage
`default_nettype wire

// ===== sv/deq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: pointers, count and response stage.
// Depends on deq_pkg, deq_ram and double_ended_queue_unit_defines.svh.
//
//   channel  | handshake           | beats
//   request  | start, busy         | req_operation, req_data_in
//   response | rsp_strobe          | rsp_data_out, rsp_status, rsp_length, rsp_is_empty
//
// One request beat per cycle while busy is low; its response beat comes in the cycle
// after acceptance: the RAM read is registered, and a pop reads the RAM at acceptance.
// busy is high during reset and in the cycle after it, and low otherwise.
// The response strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
`include "double_ended_queue_unit_defines.svh"
module double_ended_queue_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_data_in,
   output logic             rsp_strobe,
   output logic [31:0]      rsp_data_out,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_length,
   output logic             rsp_is_empty
);
   logic                  busy_ff;
   deq_pkg::addr_type     head_ff, head_in;
   deq_pkg::count_type    count_ff, count_in;
   logic                  strobe_ff;
   logic                  pop_ok_ff, pop_ok_in;
   deq_pkg::status_type   status_ff, status_in;
   deq_pkg::count_type    length_ff;
   logic                  accept;
   logic                  full, empty;
   deq_pkg::sum_type      rear_sum;
   deq_pkg::addr_type     rear_slot, last_slot, head_dec, head_inc;
   logic                  wr_en;
   deq_pkg::addr_type     wr_addr, rd_addr;
   deq_pkg::data_type     rd_data;

   assign accept = start & ~busy_ff;
   assign full   = (count_ff >= deq_pkg::count_type'(deq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      rear_sum = deq_pkg::sum_type'(head_ff) + deq_pkg::sum_type'(count_ff);
      if (rear_sum >= deq_pkg::sum_type'(deq_pkg::DEPTH)) begin
         rear_sum = rear_sum - deq_pkg::sum_type'(deq_pkg::DEPTH);
      end
      rear_slot = deq_pkg::addr_type'(rear_sum);
      last_slot = (rear_slot == '0) ? deq_pkg::addr_type'(deq_pkg::DEPTH - 1)
                                    : rear_slot - 1'b1;
      head_dec  = (head_ff == '0) ? deq_pkg::addr_type'(deq_pkg::DEPTH - 1)
                                  : head_ff - 1'b1;
      head_inc  = (head_ff == deq_pkg::addr_type'(deq_pkg::DEPTH - 1)) ? '0
                                                                     : head_ff + 1'b1;
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = rear_slot;
      rd_addr   = head_ff;
      status_in = deq_pkg::ST_OK;
      pop_ok_in = 1'b0;
      case (req_operation)
         deq_pkg::OP_PUSH_REAR: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_REAR: begin
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               rd_addr   = last_slot;
               count_in  = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   deq_ram #(
      .WIDTH (deq_pkg::DATA_WIDTH),
      .DEPTH (deq_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en & accept),
      .wr_addr (wr_addr),
      .wr_data (req_data_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         strobe_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff <= pop_ok_in;
         status_ff <= status_in;
         length_ff <= count_in;
      end
   end

   assign busy         = busy_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_data_out = pop_ok_ff ? rd_data : '0;
   assign rsp_status   = status_ff;
   assign rsp_length   = deq_pkg::length_type'(length_ff);
   assign rsp_is_empty = (length_ff == '0);

   `DEQ_ASSERT_NEXT(a_beat_follows, clock, reset, accept, rsp_strobe, "missing response beat")
   `DEQ_ASSERT_NEXT(a_no_spurious, clock, reset, !accept, !rsp_strobe, "spurious response beat")
   `DEQ_ASSERT_SAME(a_count_range, clock, reset, 1'b1,
      count_ff <= deq_pkg::count_type'(deq_pkg::DEPTH), "entry count beyond depth")
   `DEQ_ASSERT_SAME(a_full_length, clock, reset, rsp_strobe && rsp_status == deq_pkg::ST_FULL,
      rsp_length == deq_pkg::length_type'(deq_pkg::DEPTH), "full status with spare room")
   `DEQ_ASSERT_SAME(a_empty_length, clock, reset, rsp_strobe && rsp_status == deq_pkg::ST_EMPTY,
      rsp_length == '0 && rsp_data_out == '0, "empty status with entries or data")
endmodule
`default_nettype wire
